### rtl/tps_pkg.sv
// Shared types, constants and byte classification functions for the text pre-tokenize splitter.
package tps_pkg;

    localparam int CONTRACTION_LOOKAHEAD = 3;
    localparam int MAX_RESULTS           = 4;
    localparam int FIFO_DEPTH            = 8;
    localparam int FIFO_AW               = 3;
    localparam int FIFO_CW               = 4;

    // Piece kinds held in the state register.
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_NEWLINE = 3'd1;
    localparam logic [2:0] KIND_SPACE   = 3'd2;
    localparam logic [2:0] KIND_WSRUN   = 3'd3;
    localparam logic [2:0] KIND_LETTER  = 3'd4;
    localparam logic [2:0] KIND_WIDE    = 3'd5;
    localparam logic [2:0] KIND_PUNCT   = 3'd6;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_APOS  = 8'h27;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    typedef struct packed {
        logic       last;
        logic       start;
        logic [7:0] data;
    } res_t;

    typedef struct packed {
        logic                         valid;
        logic [2:0]                   count;
        res_t [MAX_RESULTS-1:0]       item;
    } step_out_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] rem;
        logic       hold;
        logic       start;
    } feed_t;

    typedef struct packed {
        logic [1:0]                                n;
        logic [CONTRACTION_LOOKAHEAD-1:0][7:0]     data;
        logic [CONTRACTION_LOOKAHEAD-1:0]          start;
        logic [2:0]                                kind;
    } resolve_t;

    function automatic logic is_letter(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_TAB);
    endfunction

    function automatic logic is_eol(input logic [7:0] b);
        return (b == CHAR_LF) || (b == CHAR_CR);
    endfunction

    function automatic logic is_space6(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b inside {[CHAR_TAB:CHAR_CR]});
    endfunction

    // Continuation bytes still to come after a UTF-8 lead byte.
    function automatic logic [1:0] extra_bytes(input logic [7:0] b);
        if (b < 8'hC0) return 2'd0;
        if (b < 8'hE0) return 2'd1;
        if (b < 8'hF0) return 2'd2;
        return 2'd3;
    endfunction

    function automatic logic is_contraction(input logic [7:0] l1, input logic [7:0] l2,
                                            input logic [1:0] k);
        logic [7:0] a;
        logic [7:0] c;
        a = l1 | CASE_BIT;
        c = l2 | CASE_BIT;
        if (k == 2'd1) return a inside {"s", "t", "m", "d"};
        if (k == 2'd2) return ((a == "r") && (c == "e")) || ((a == "v") && (c == "e")) ||
                              ((a == "l") && (c == "l"));
        return 1'b0;
    endfunction

    // One byte against the open piece: either it is held (apostrophe after a word)
    // or it is passed on, opening a new piece where it cannot join the current one.
    function automatic feed_t feed_byte(input logic [2:0] kind, input logic [1:0] rem,
                                        input logic [7:0] b);
        feed_t f;
        logic  cont;
        f.kind  = kind;
        f.rem   = rem;
        f.hold  = 1'b0;
        f.start = 1'b0;
        cont    = 1'b0;
        case (kind)
            KIND_NEWLINE: cont = is_eol(b);
            KIND_SPACE: begin
                if (is_letter(b)) begin
                    cont   = 1'b1;
                    f.kind = KIND_LETTER;
                end else if (b[7]) begin
                    cont   = 1'b1;
                    f.kind = KIND_WIDE;
                    f.rem  = extra_bytes(b);
                end else if (is_digit(b)) begin
                    cont = 1'b0;
                end else if (is_blank(b)) begin
                    cont   = 1'b1;
                    f.kind = KIND_WSRUN;
                end else if (is_space6(b)) begin
                    cont = 1'b0;
                end else begin
                    cont   = 1'b1;
                    f.kind = KIND_PUNCT;
                end
            end
            KIND_WSRUN: cont = is_blank(b);
            KIND_LETTER: begin
                if (is_letter(b)) cont = 1'b1;
                else if (b == CHAR_APOS) f.hold = 1'b1;
            end
            KIND_WIDE: begin
                if (rem != 2'd0) begin
                    f.rem = rem - 2'd1;
                    cont  = 1'b1;
                end else if (b[7]) begin
                    f.rem = extra_bytes(b);
                    cont  = 1'b1;
                end
            end
            KIND_PUNCT: cont = !b[7] && !is_space6(b) && !is_letter(b) && !is_digit(b);
            default: cont = 1'b0;
        endcase
        if (!f.hold && !cont) begin
            f.rem   = 2'd0;
            f.start = 1'b1;
            if (is_eol(b)) f.kind = KIND_NEWLINE;
            else if (is_blank(b)) f.kind = KIND_SPACE;
            else if (is_letter(b)) f.kind = KIND_LETTER;
            else if (b[7]) begin
                f.kind = KIND_WIDE;
                f.rem  = extra_bytes(b);
            end else f.kind = KIND_NONE;
        end
        return f;
    endfunction

    // Decide the held apostrophe and letters. Without a contraction the first
    // held letter opens a new word.
    function automatic resolve_t resolve_held(input logic [CONTRACTION_LOOKAHEAD-1:0][7:0] la,
                                              input logic [1:0] cnt, input logic may_match);
        resolve_t r;
        r.n     = cnt;
        r.data  = la;
        r.start = '0;
        r.kind  = KIND_NONE;
        if (cnt != 2'd0) begin
            r.start[0] = 1'b1;
            if (!(may_match && is_contraction(la[1], la[2], cnt - 2'd1)) && (cnt >= 2'd2)) begin
                r.start[1] = 1'b1;
                r.kind     = KIND_LETTER;
            end
        end
        return r;
    endfunction

endpackage

### rtl/text_pretokenize_splitter_core.sv
// An accepted byte is held in the input register, decided there and written to the eight-entry
// result queue; an apostrophe after a word waits with the letters after it until a later byte
// or the end of text settles the contraction. Bytes go in and out at one per cycle while the
// queue has room for a full burst and the receiver is ready.
// Reset (aresetn low, synchronous) empties the input register and the queue and closes any piece.
// Top level of the text pre-tokenize splitter.
module text_pretokenize_splitter_core import tps_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser,   // [0] piece_start
    output logic       m_tlast
);

    step_out_t step_out;
    logic      space_ok;
    res_t      rd_item;

    tps_step u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .space_ok (space_ok),
        .step_out (step_out)
    );

    tps_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (step_out),
        .space_ok (space_ok),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_item  (rd_item)
    );

    assign m_tdata    = rd_item.data;
    assign m_tuser[0] = rd_item.start;
    assign m_tlast    = rd_item.last;

endmodule

### rtl/tps_step.sv
// Input register, piece state and the per-byte splitting decision.
module tps_step import tps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] in_byte,
    input  logic      in_last,
    input  logic      space_ok,
    output step_out_t step_out
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic [2:0] kind_reg, kind_next;
    logic [1:0] rem_reg, rem_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pend_reg, pend_next;
    logic [CONTRACTION_LOOKAHEAD-1:0][7:0] la_reg, la_next;

    logic                   consume;
    logic                   do_feed;
    logic [2:0]             n;
    logic [2:0]             n_m1;
    res_t [MAX_RESULTS-1:0] items;
    resolve_t               rs_a;
    resolve_t               rs_b;
    feed_t                  fd;

    assign consume  = in_valid_reg && space_ok;
    assign in_ready = !in_valid_reg || space_ok;

    always_comb begin
        kind_next = kind_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        pend_next = pend_reg;
        la_next   = la_reg;
        n         = 3'd0;
        n_m1      = 3'd0;
        items     = '0;
        do_feed   = 1'b1;
        rs_a      = '0;
        rs_b      = '0;
        fd        = '0;

        if (pend_reg) begin
            if (is_letter(in_byte_reg) && (cnt_reg != 2'd3)) begin
                la_next[cnt_reg] = in_byte_reg;
                cnt_next         = cnt_reg + 2'd1;
                do_feed          = 1'b0;
            end else begin
                // A third letter rules out a contraction; any other byte ends the word.
                rs_a = resolve_held(la_reg, cnt_reg, !is_letter(in_byte_reg));
                for (int j = 0; j < CONTRACTION_LOOKAHEAD; j++) begin
                    if (j < int'(rs_a.n)) begin
                        items[n[1:0]].last  = 1'b0;
                        items[n[1:0]].start = rs_a.start[j];
                        items[n[1:0]].data  = rs_a.data[j];
                        n = n + 3'd1;
                    end
                end
                kind_next = rs_a.kind;
                rem_next  = 2'd0;
                pend_next = 1'b0;
                cnt_next  = 2'd0;
            end
        end

        if (do_feed) begin
            fd        = feed_byte(kind_next, rem_next, in_byte_reg);
            kind_next = fd.kind;
            rem_next  = fd.rem;
            if (fd.hold) begin
                la_next[0] = in_byte_reg;
                cnt_next   = 2'd1;
                pend_next  = 1'b1;
            end else begin
                items[n[1:0]].last  = 1'b0;
                items[n[1:0]].start = fd.start;
                items[n[1:0]].data  = in_byte_reg;
                n = n + 3'd1;
            end
        end

        if (in_last_reg) begin
            if (pend_next) begin
                rs_b = resolve_held(la_next, cnt_next, 1'b1);
                for (int j = 0; j < CONTRACTION_LOOKAHEAD; j++) begin
                    if ((j < int'(rs_b.n)) && (n != 3'd4)) begin
                        items[n[1:0]].last  = 1'b0;
                        items[n[1:0]].start = rs_b.start[j];
                        items[n[1:0]].data  = rs_b.data[j];
                        n = n + 3'd1;
                    end
                end
            end
            if (n != 3'd0) begin
                n_m1 = n - 3'd1;
                items[n_m1[1:0]].last = 1'b1;
            end
            kind_next = KIND_NONE;
            rem_next  = 2'd0;
            cnt_next  = 2'd0;
            pend_next = 1'b0;
        end
    end

    assign step_out.valid = consume;
    assign step_out.count = n;
    assign step_out.item  = items;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            kind_reg     <= KIND_NONE;
            rem_reg      <= 2'd0;
            cnt_reg      <= 2'd0;
            pend_reg     <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                kind_reg <= kind_next;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_next;
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
        if (consume) begin
            la_reg <= la_next;
        end
    end

endmodule

### rtl/tps_fifo.sv
// Result queue: takes up to four beats a cycle from the splitter and hands out one.
module tps_fifo import tps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  step_out_t wr,
    output logic      space_ok,
    output logic      rd_valid,
    input  logic      rd_ready,
    output res_t      rd_item
);

    res_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic [FIFO_CW-1:0]   wr_n;
    logic                 pop;

    // Room for a full burst is checked against the registered fill level only.
    assign space_ok = count_reg <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS);
    assign rd_valid = count_reg != '0;
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;
    assign wr_n     = wr.valid ? FIFO_CW'(wr.count) : '0;

    assign wr_ptr_next = wr_ptr_reg + wr_n[FIFO_AW-1:0];
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + wr_n - FIFO_CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (wr.valid && (j < int'(wr.count))) begin
                mem_reg[wr_ptr_reg + FIFO_AW'(j)] <= wr.item[j];
            end
        end
    end

endmodule

### rtl/tps_checker.sv
// Port-level assertions for the splitter, bound to the top level.
module tps_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    // High when the next output beat is the first of a text.
    logic first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            first_reg <= m_tlast;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
        $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    a_stall_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled while no result is queued");

    a_text_opens_piece: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && first_reg |-> m_tuser[0])
        else $error("first byte of a text does not open a piece");

endmodule

bind text_pretokenize_splitter_core tps_checker u_tps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/text_pretokenize_splitter_checker.sv
// Result checker for the text pre-tokenize splitter: predicts piece starts and compares beats.
`timescale 1ns / 1ps

module text_pretokenize_splitter_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [0:0] m_tuser,
    input  logic       m_tlast,
    output int         failures,
    output int         results_due
);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam int         HOLD_MAX = 3;
    localparam int         STEP_MAX = 4;

    typedef enum logic [2:0] {
        RUN_NONE, RUN_EOL, RUN_BLANK1, RUN_BLANKS, RUN_WORD, RUN_WIDE, RUN_PUNCT
    } run_kind_t;

    typedef struct packed {
        logic [7:0] text;
        logic       opens;
        logic       final_byte;
    } piece_byte_t;

    run_kind_t   run_kind;
    logic [7:0]  held [HOLD_MAX];
    int          held_n;
    bit          apos_open;
    logic [1:0]  utf_left;
    piece_byte_t step_out [$];
    piece_byte_t due_bytes [$];
    int          mismatch_n;

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB;
    endfunction

    function automatic bit is_eol(input logic [7:0] b);
        return b == CH_LF || b == CH_CR;
    endfunction

    function automatic bit is_ws6(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic [1:0] lead_extra(input logic [7:0] b);
        if (b < 8'hC0) return 2'd0;
        if (b < 8'hE0) return 2'd1;
        if (b < 8'hF0) return 2'd2;
        return 2'd3;
    endfunction

    function automatic bit is_suffix(input logic [7:0] l1, input logic [7:0] l2, input int k);
        logic [7:0] a;
        logic [7:0] c;
        a = l1 | 8'h20;
        c = l2 | 8'h20;
        if (k == 1) return a == "s" || a == "t" || a == "m" || a == "d";
        if (k == 2) return (a == "r" && c == "e") || (a == "v" && c == "e") ||
                           (a == "l" && c == "l");
        return 1'b0;
    endfunction

    task automatic clear_runs();
        run_kind  = RUN_NONE;
        held      = '{default: 8'h00};
        held_n    = 0;
        apos_open = 1'b0;
        utf_left  = 2'd0;
    endtask

    task automatic push_out(input logic [7:0] b, input logic opens);
        piece_byte_t p;
        p.text       = b;
        p.opens      = opens;
        p.final_byte = 1'b0;
        if (step_out.size() < STEP_MAX) step_out = {step_out, p};
    endtask

    // One byte against the open run; an apostrophe after a word is held instead.
    task automatic split_byte(input logic [7:0] b);
        bit joins;
        joins = 1'b0;
        case (run_kind)
            RUN_EOL: joins = is_eol(b);
            RUN_BLANK1: begin
                if (is_alpha(b)) begin
                    joins    = 1'b1;
                    run_kind = RUN_WORD;
                end else if (b[7]) begin
                    joins    = 1'b1;
                    run_kind = RUN_WIDE;
                    utf_left = lead_extra(b);
                end else if (is_num(b)) begin
                    joins = 1'b0;
                end else if (is_blank(b)) begin
                    joins    = 1'b1;
                    run_kind = RUN_BLANKS;
                end else if (is_ws6(b)) begin
                    joins = 1'b0;
                end else begin
                    joins    = 1'b1;
                    run_kind = RUN_PUNCT;
                end
            end
            RUN_BLANKS: joins = is_blank(b);
            RUN_WORD: begin
                if (is_alpha(b)) begin
                    joins = 1'b1;
                end else if (b == CH_APOS) begin
                    held[0]   = b;
                    held_n    = 1;
                    apos_open = 1'b1;
                    return;
                end
            end
            RUN_WIDE: begin
                if (utf_left != 2'd0) begin
                    utf_left = utf_left - 2'd1;
                    joins    = 1'b1;
                end else if (b[7]) begin
                    utf_left = lead_extra(b);
                    joins    = 1'b1;
                end
            end
            RUN_PUNCT: joins = !b[7] && !is_ws6(b) && !is_alpha(b) && !is_num(b);
            default: joins = 1'b0;
        endcase
        if (joins) begin
            push_out(b, 1'b0);
            return;
        end
        utf_left = 2'd0;
        if (is_eol(b)) run_kind = RUN_EOL;
        else if (is_blank(b)) run_kind = RUN_BLANK1;
        else if (is_alpha(b)) run_kind = RUN_WORD;
        else if (b[7]) begin
            run_kind = RUN_WIDE;
            utf_left = lead_extra(b);
        end else run_kind = RUN_NONE;
        push_out(b, 1'b1);
    endtask

    // Decide the held apostrophe and the letters after it.
    task automatic settle_apostrophe(input bit may_match);
        logic [7:0] h [HOLD_MAX];
        int         k;
        int         i;
        h         = held;
        k         = held_n;
        apos_open = 1'b0;
        held_n    = 0;
        held      = '{default: 8'h00};
        run_kind  = RUN_NONE;
        utf_left  = 2'd0;
        if (k == 0) return;
        push_out(h[0], 1'b1);
        if (may_match && is_suffix(h[1], h[2], k - 1)) begin
            for (i = 1; i < k; i++) push_out(h[i], 1'b0);
            return;
        end
        for (i = 1; i < k; i++) split_byte(h[i]);
    endtask

    task automatic take_text_byte(input logic [7:0] b, input logic eot);
        step_out.delete();
        if (apos_open) begin
            if (is_alpha(b) && held_n < HOLD_MAX) begin
                held[held_n] = b;
                held_n++;
            end else if (is_alpha(b)) begin
                settle_apostrophe(1'b0);
                split_byte(b);
            end else begin
                settle_apostrophe(1'b1);
                split_byte(b);
            end
        end else begin
            split_byte(b);
        end
        if (eot) begin
            if (apos_open) settle_apostrophe(1'b1);
            if (step_out.size() > 0) step_out[step_out.size() - 1].final_byte = 1'b1;
            clear_runs();
        end
        due_bytes = {due_bytes, step_out};
    endtask

    task automatic note_mismatch(input piece_byte_t want, input piece_byte_t got,
                                 input bit none_due);
        if (mismatch_n < 10) begin
            if (none_due)
                $display("%0t: unexpected result beat: byte %02h start %0b last %0b",
                         $realtime, got.text, got.opens, got.final_byte);
            else begin
                $write("%0t: result beat differs: expected byte %02h start %0b last %0b,",
                       $realtime, want.text, want.opens, want.final_byte);
                $display(" got byte %02h start %0b last %0b",
                         got.text, got.opens, got.final_byte);
            end
        end
        mismatch_n++;
    endtask

    initial begin
        clear_runs();
        mismatch_n  = 0;
        failures    = 0;
        results_due = 0;
    end

    always @(posedge aclk) begin
        piece_byte_t got;
        piece_byte_t want;
        if (!aresetn) begin
            clear_runs();
            due_bytes.delete();
        end else begin
            if (s_tvalid && s_tready) take_text_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.text       = m_tdata;
                got.opens      = m_tuser[0];
                got.final_byte = m_tlast;
                if (due_bytes.size() == 0) begin
                    want = '0;
                    note_mismatch(want, got, 1'b1);
                end else begin
                    want = due_bytes.pop_front();
                    if (got.text != want.text || got.opens != want.opens ||
                        got.final_byte != want.final_byte)
                        note_mismatch(want, got, 1'b0);
                end
            end
        end
        results_due <= due_bytes.size();
        failures    <= mismatch_n;
    end

endmodule

### tb/text_pretokenize_splitter_core_tb.sv
// Testbench top for the text pre-tokenize splitter: clock, reset, text stimulus and verdict.
`timescale 1ns / 1ps

module text_pretokenize_splitter_core_tb;

    localparam int RANDOM_BYTES = 392;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 16;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;

    int         fail_count;
    int         results_due;
    int         tx_idle_pct  = 17;
    int         rx_idle_pct  = 84;
    int         stall_cycles = 0;

    logic [7:0] text_q [$];
    bit         eot_q [$];

    string apos_tails [12] = '{"'s", "'t", "'re", "'ve", "'m", "'ll", "'d", "'", "'x",
                               "'rez", "'dl", "'llama"};

    text_pretokenize_splitter_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    text_pretokenize_splitter_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .failures    (fail_count),
        .results_due (results_due)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b, input bit eot);
        text_q = {text_q, b};
        eot_q  = {eot_q, eot};
    endtask

    task automatic add_text(input string s, input bit eot);
        int i;
        for (i = 0; i < s.len(); i++) add_byte(s[i], eot && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] any_letter();
        logic [7:0] b;
        b = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) b = b ^ 8'h20;
        return b;
    endfunction

    // Mostly well-formed fragments of text, with some raw noise mixed in.
    task automatic add_fragment();
        int         pick;
        int         n;
        int         i;
        string      tail;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) add_byte(any_letter(), 1'b0);
        end else if (pick < 42) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) add_byte(any_letter(), 1'b0);
            tail = apos_tails[$urandom_range(0, 11)];
            for (i = 0; i < tail.len(); i++) begin
                b = tail[i];
                if (b != "'" && $urandom_range(0, 1)) b = b ^ 8'h20;
                add_byte(b, 1'b0);
            end
        end else if (pick < 54) begin
            add_byte($urandom_range(0, 1) ? 8'h20 : 8'h09, 1'b0);
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) add_byte(any_letter(), 1'b0);
        end else if (pick < 60) begin
            n = $urandom_range(2, 4);
            for (i = 0; i < n; i++) add_byte($urandom_range(0, 1) ? 8'h20 : 8'h09, 1'b0);
        end else if (pick < 66) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) add_byte(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
        end else if (pick < 72) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) add_byte($urandom_range(0, 1) ? 8'h0D : 8'h0A, 1'b0);
        end else if (pick < 78) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                do begin
                    b = 8'($urandom_range(0, 127));
                end while ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                           (b >= "0" && b <= "9") || b == 8'h20 ||
                           (b >= 8'h09 && b <= 8'h0D));
                add_byte(b, 1'b0);
            end
        end else if (pick < 90) begin
            // A lead byte with the continuation count it asks for.
            b = 8'($urandom_range(8'h80, 8'hFF));
            add_byte(b, 1'b0);
            n = (b < 8'hC0) ? 0 : (b < 8'hE0) ? 1 : (b < 8'hF0) ? 2 : 3;
            for (i = 0; i < n; i++) add_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
        end else begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        if ($urandom_range(0, 11) == 0) eot_q[eot_q.size() - 1] = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] b, input bit eot);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    initial begin
        int i;
        int first_random;
        int span;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // An upper-case contraction, a third letter after the apostrophe, blank runs,
        // space before a digit, a vertical tab and a line break, control punctuation,
        // ASCII inside a UTF-8 sequence, an apostrophe at the end of text, and a
        // stray continuation byte followed by a cut-off sequence.
        add_text("i'S a'rex \t7 ", 1'b0);
        add_byte(8'h0B, 1'b0);
        add_text(" \r\n !", 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte("A", 1'b0);
        add_byte(8'hFF, 1'b0);
        add_text("z'", 1'b1);
        add_byte(8'h80, 1'b0);
        add_byte(8'hF4, 1'b0);
        add_text("b", 1'b1);
        first_random = text_q.size();
        while (text_q.size() < first_random + RANDOM_BYTES) add_fragment();
        eot_q[eot_q.size() - 1] = 1'b1;
        span = (text_q.size() - first_random) / 3;

        for (i = 0; i < first_random; i++) send_byte(text_q[i], eot_q[i]);
        wait_for_results();
        for (i = first_random; i < text_q.size(); i++) begin
            if (i == first_random + span) begin
                wait_for_results();
                tx_idle_pct = 84;
                rx_idle_pct <= 17;
            end
            if (i == first_random + 2 * span) begin
                wait_for_results();
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            send_byte(text_q[i], eot_q[i]);
        end
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && results_due == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
